@@ hdl/bal_pkg.sv @@
// Shared types, constants and the log2 fraction table for the barometric altitude block.
`default_nettype none

package bal_pkg;

    localparam int LOG_TABLE_ENTRIES = 64;
    localparam int LOG_BITS          = $clog2(LOG_TABLE_ENTRIES);

    localparam logic [16:0] P_MIN        = 17'd1000;
    localparam logic [16:0] P_MAX        = 17'd120000;
    localparam logic [16:0] SEA_RESET    = 17'd101325;
    localparam logic [23:0] K_ALT        = 24'd13296794;
    localparam logic [15:0] KELVIN_CENTI = 16'd27300;

    localparam logic [28:0] POS_LIMIT = 29'd67108863;
    localparam logic [28:0] NEG_LIMIT = 29'd67108864;
    localparam logic signed [26:0] OUT_MAX = 27'sh3FFFFFF;
    localparam logic signed [26:0] OUT_MIN = 27'sh4000000;

    typedef logic [15:0] t_log_table [LOG_TABLE_ENTRIES];

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG_MUL,
        S_LOG_ADD,
        S_KT_MUL,
        S_PP_LO,
        S_PP_HI,
        S_ROUND,
        S_DONE
    } t_eng_state;

    typedef struct packed {
        logic        start;
        logic [16:0] pressure;
        logic [16:0] sea_level;
        logic [15:0] tk;
    } t_eng_req;

    typedef struct packed {
        logic               done;
        logic signed [26:0] alt;
    } t_eng_rsp;

    typedef struct packed {
        logic [4:0]  e;
        logic [15:0] lo;
        logic [16:0] diff;
        logic [15:0] rem;
    } t_log_terms;

    function automatic t_log_table build_log_table();
        t_log_table  tab;
        logic [63:0] x;
        logic [15:0] f;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
            x = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / 64'(LOG_TABLE_ENTRIES);
            f = '0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                f = {f[14:0], 1'b0};
                if (x >= 64'h8000_0000) begin
                    f[0] = 1'b1;
                    x    = x >> 1;
                end
            end
            tab[i] = f;
        end
        return tab;
    endfunction

    localparam t_log_table LOG_TABLE = build_log_table();

    function automatic logic [16:0] clamp_p(input logic [16:0] v);
        logic [16:0] c;
        if (v < P_MIN) begin
            c = P_MIN;
        end else if (v > P_MAX) begin
            c = P_MAX;
        end else begin
            c = v;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/baro_altitude_and_height_top.sv @@
// Top level of the barometric altitude and height-above-launch block.
`default_nettype none

// Each accepted item is a timestamped pressure and temperature sample; one result item follows
// with the timestamp, the altitude in millimetres from the hypsometric formula and the height
// above the launch altitude, which is captured from each result up to the first one with
// a non-zero timestamp. From acceptance to the output register an item goes through two steps per
// logarithm (table step, then interpolation), three passes through the one shared 24 x 20
// bit multiplier for the scaling product, one step for rounding and one to hand over. The
// input stall stays high from acceptance until the result has moved to the output register,
// which then waits for the receiver on its own while the next item is taken.
module baro_altitude_and_height_top
    import bal_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [16:0]        i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [63:0]        i_sample_time,
    input  wire logic [16:0]        i_pressure_pa,
    input  wire logic signed [14:0] i_temperature_centi,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [63:0]             o_result_time,
    output logic signed [26:0]      o_altitude_mm,
    output logic signed [26:0]      o_height_mm
);

    logic [16:0]        r_sea_level;
    logic               r_busy;
    logic [63:0]        r_time;
    logic               r_launched;
    logic signed [26:0] r_origin_alt;
    logic               r_out_valid;
    logic [63:0]        r_out_time;
    logic signed [26:0] r_out_alt;
    logic signed [26:0] r_out_h;

    t_eng_req           req;
    t_eng_rsp           rsp;
    logic               accept;
    logic               ack;
    logic signed [26:0] base;
    logic signed [27:0] hdiff;
    logic signed [26:0] h_sat;

    assign accept = i_valid && !r_busy;
    assign ack    = rsp.done && (!r_out_valid || !i_stall);

    always_comb begin
        req.start     = accept;
        req.pressure  = i_pressure_pa;
        req.sea_level = r_sea_level;
        req.tk        = 16'({i_temperature_centi[14], i_temperature_centi}) + KELVIN_CENTI;
    end

    bal_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_ack   (ack),
        .o_rsp   (rsp)
    );

    always_comb begin
        base  = r_launched ? r_origin_alt : rsp.alt;
        hdiff = 28'(rsp.alt) - 28'(base);
        if (hdiff > 28'(OUT_MAX)) begin
            h_sat = OUT_MAX;
        end else if (hdiff < 28'(OUT_MIN)) begin
            h_sat = OUT_MIN;
        end else begin
            h_sat = 27'(hdiff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sea_level  <= SEA_RESET;
            r_busy       <= 1'b0;
            r_launched   <= 1'b0;
            r_origin_alt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sea_level <= i_cfg_wr_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (ack) begin
                r_busy <= 1'b0;
            end
            if (ack) begin
                r_out_valid <= 1'b1;
                if (!r_launched) begin
                    r_origin_alt <= rsp.alt;
                    r_launched   <= (r_time != 64'd0);
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time <= i_sample_time;
        end
        if (ack) begin
            r_out_time <= r_time;
            r_out_alt  <= rsp.alt;
            r_out_h    <= h_sat;
        end
    end

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_result_time = r_out_time;
    assign o_altitude_mm = r_out_alt;
    assign o_height_mm   = r_out_h;

endmodule

`default_nettype wire

@@ hdl/bal_log_front.sv @@
// Leading-one search, table lookup and interpolation terms for the base-two logarithm.
`default_nettype none

module bal_log_front
    import bal_pkg::*;
(
    input  wire logic [16:0] i_value,
    output t_log_terms       o_terms
);

    logic [4:0]               e;
    logic [16:0]              lead;
    logic [15:0]              frac;
    logic [16+LOG_BITS-1:0]   scaled;
    logic [16+LOG_BITS-1:0]   mask;
    logic [LOG_BITS-1:0]      idx;
    logic [16:0]              hi;
    logic [15:0]              lo;

    always_comb begin
        e = '0;
        for (int b = 0; b < 17; b++) begin
            if (i_value[b]) begin
                e = 5'(b);
            end
        end
        lead   = 17'(1) << e;
        frac   = 16'(i_value - lead);
        scaled = {frac, {LOG_BITS{1'b0}}};
        mask   = ((16+LOG_BITS)'(1) << e) - (16+LOG_BITS)'(1);
        idx    = LOG_BITS'(scaled >> e);
        lo     = LOG_TABLE[idx];
        if (idx == LOG_BITS'(LOG_TABLE_ENTRIES - 1)) begin
            hi = 17'h10000;
        end else begin
            hi = {1'b0, LOG_TABLE[idx + LOG_BITS'(1)]};
        end
        o_terms.e    = e;
        o_terms.lo   = lo;
        o_terms.diff = hi - {1'b0, lo};
        o_terms.rem  = 16'(scaled & mask);
    end

endmodule

`default_nettype wire

@@ hdl/bal_engine.sv @@
// Sequencer and datapath that evaluate the altitude on one shared multiplier.
`default_nettype none

module bal_engine
    import bal_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_eng_req i_req,
    input  wire logic i_ack,
    output t_eng_rsp  o_rsp
);

    t_eng_state r_state, n_state;

    logic [16:0]        r_p;
    logic [16:0]        r_ps;
    logic [15:0]        r_tk;
    logic               r_sel;
    logic [4:0]         r_e;
    logic [15:0]        r_lo;
    logic [43:0]        r_prod;
    logic [20:0]        r_log_s;
    logic               r_neg;
    logic [19:0]        r_mag;
    logic [39:0]        r_kt;
    logic [59:0]        r_acc;
    logic signed [26:0] r_alt;

    t_log_terms         terms;
    logic [16:0]        log_in;
    logic [23:0]        mul_a;
    logic [19:0]        mul_b;
    logic [43:0]        mul_p;
    logic [43:0]        interp;
    logic [20:0]        log_val;
    logic signed [21:0] d;
    logic [60:0]        rsum;
    logic [28:0]        rnd;
    logic signed [26:0] alt_n;

    assign log_in = r_sel ? r_p : r_ps;

    bal_log_front u_log_front (
        .i_value (log_in),
        .o_terms (terms)
    );

    always_comb begin
        case (r_state)
            S_LOG_MUL: begin
                mul_a = 24'(terms.diff);
                mul_b = 20'(terms.rem);
            end
            S_KT_MUL: begin
                mul_a = K_ALT;
                mul_b = 20'(r_tk);
            end
            S_PP_LO: begin
                mul_a = 24'(r_kt[19:0]);
                mul_b = r_mag;
            end
            S_PP_HI: begin
                mul_a = 24'(r_kt[39:20]);
                mul_b = r_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 44'(mul_a) * 44'(mul_b);
    end

    always_comb begin
        interp  = r_prod >> r_e;
        log_val = {r_e, 16'h0000} + 21'(r_lo) + 21'(interp[16:0]);
        d       = $signed({1'b0, r_log_s}) - $signed({1'b0, log_val});
        rsum    = 61'(r_acc) + (61'(1) << 31);
        rnd     = rsum[60:32];
        if (r_neg) begin
            alt_n = (rnd > NEG_LIMIT) ? OUT_MIN : $signed(27'(~rnd + 29'd1));
        end else begin
            alt_n = (rnd > POS_LIMIT) ? OUT_MAX : $signed(27'(rnd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_rsp.done = 1'b0;
        o_rsp.alt  = r_alt;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = S_LOG_MUL;
                end
            end
            S_LOG_MUL: begin
                n_state = S_LOG_ADD;
            end
            S_LOG_ADD: begin
                n_state = r_sel ? S_KT_MUL : S_LOG_MUL;
            end
            S_KT_MUL: begin
                n_state = S_PP_LO;
            end
            S_PP_LO: begin
                n_state = S_PP_HI;
            end
            S_PP_HI: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp.done = 1'b1;
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    r_p   <= clamp_p(i_req.pressure);
                    r_ps  <= clamp_p(i_req.sea_level);
                    r_tk  <= i_req.tk;
                    r_sel <= 1'b0;
                end
            end
            S_LOG_MUL: begin
                r_prod <= mul_p;
                r_e    <= terms.e;
                r_lo   <= terms.lo;
            end
            S_LOG_ADD: begin
                if (!r_sel) begin
                    r_log_s <= log_val;
                    r_sel   <= 1'b1;
                end else begin
                    r_neg <= d[21];
                    r_mag <= d[21] ? 20'(-d) : 20'(d);
                end
            end
            S_KT_MUL: begin
                r_kt <= mul_p[39:0];
            end
            S_PP_LO: begin
                r_acc <= 60'(mul_p);
            end
            S_PP_HI: begin
                r_acc <= r_acc + {mul_p[39:0], 20'h00000};
            end
            S_ROUND: begin
                r_alt <= alt_n;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bal_checker.sv @@
// Port-level checker for the barometric altitude block, bound to its top level.
`default_nettype none

module bal_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_cfg_wr_en,
    input wire logic [16:0]        i_cfg_wr_data,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic [63:0]        i_sample_time,
    input wire logic [16:0]        i_pressure_pa,
    input wire logic signed [14:0] i_temperature_centi,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [63:0]        o_result_time,
    input wire logic signed [26:0] o_altitude_mm,
    input wire logic signed [26:0] o_height_mm
);

    // Reset leaves no result pending and the input side open.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall set after reset");

    // An accepted item holds off the next one until its result is produced.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again before a result was produced");

    // A new result only appears while an item was in progress.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in progress");

    // A stalled result keeps its payload.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_time)
            && $stable(o_altitude_mm) && $stable(o_height_mm))
        else $error("stalled result changed");

endmodule

bind baro_altitude_and_height_top bal_checker u_bal_checker (.*);

`default_nettype wire

@@ tb/baro_altitude_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the altitude and height of each accepted sample and compares the results.
module baro_altitude_checker
    import bal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [16:0]        i_cfg_wr_data,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [63:0]        i_sample_time,
    input  logic [16:0]        i_pressure_pa,
    input  logic signed [14:0] i_temperature_centi,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [63:0]        o_result_time,
    input  logic signed [26:0] o_altitude_mm,
    input  logic signed [26:0] o_height_mm,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [63:0]        stamp;
        logic signed [26:0] altitude;
        logic signed [26:0] height;
    } t_altitude_result;

    logic [15:0]        frac_table [LOG_TABLE_ENTRIES];
    logic [16:0]        sea_level_reg;
    logic signed [26:0] origin_alt;
    logic [63:0]        launch_stamp;
    t_altitude_result   altitude_results [$];
    int                 mismatches = 0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic [15:0] fraction_entry(input int idx);
        logic [63:0] x;
        logic [15:0] bits;
        x = ((64'(LOG_TABLE_ENTRIES) + 64'(idx)) << 30) / 64'(LOG_TABLE_ENTRIES);
        bits = '0;
        repeat (16) begin
            x = (x * x) >> 30;
            bits = bits << 1;
            if (x >= 64'h8000_0000) begin
                bits[0] = 1'b1;
                x = x >> 1;
            end
        end
        return bits;
    endfunction

    initial begin
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
            frac_table[i] = fraction_entry(i);
        end
    end

    function automatic logic [16:0] clamp_pressure(input logic [16:0] v);
        logic [16:0] c;
        c = v;
        if (v < P_MIN) begin
            c = P_MIN;
        end else if (v > P_MAX) begin
            c = P_MAX;
        end
        return c;
    endfunction

    function automatic int log2_q16(input logic [16:0] v);
        int          lead;
        logic [63:0] scaled;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        lead = 0;
        for (int b = 0; b < 17; b++) begin
            if (v[b]) begin
                lead = b;
            end
        end
        scaled = 64'(v - (17'd1 << lead)) * 64'(LOG_TABLE_ENTRIES);
        idx = scaled >> lead;
        rem = scaled & ((64'd1 << lead) - 64'd1);
        if (idx >= LOG_TABLE_ENTRIES) begin
            idx = LOG_TABLE_ENTRIES - 1;
        end
        lo = 64'(frac_table[idx]);
        hi = (idx + 1 < LOG_TABLE_ENTRIES) ? 64'(frac_table[idx + 1]) : 64'd65536;
        return (lead << 16) + int'(lo) + int'(((hi - lo) * rem) >> lead);
    endfunction

    function automatic logic signed [26:0] saturate27(input longint v);
        logic signed [26:0] s;
        if (v > longint'(OUT_MAX)) begin
            s = OUT_MAX;
        end else if (v < longint'(OUT_MIN)) begin
            s = OUT_MIN;
        end else begin
            s = v[26:0];
        end
        return s;
    endfunction

    function automatic logic signed [26:0] altitude_of(input logic [16:0] pressure,
                                                       input logic signed [14:0] temp_c);
        int          tk;
        int          d;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      alt;
        tk = int'(temp_c) + int'(KELVIN_CENTI);
        d = log2_q16(clamp_pressure(sea_level_reg)) - log2_q16(clamp_pressure(pressure));
        mag = (d < 0) ? 64'(-d) : 64'(d);
        prod = 64'(K_ALT) * 64'(tk) * mag + (64'd1 << 31);
        mag = prod >> 32;
        alt = (d < 0) ? -longint'(mag) : longint'(mag);
        return saturate27(alt);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_altitude_result want;
        logic signed [26:0] alt;
        if (!i_rst_n) begin
            sea_level_reg = SEA_RESET;
            origin_alt = '0;
            launch_stamp = '0;
            altitude_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                sea_level_reg = i_cfg_wr_data;
            end
            if (o_valid && !i_stall) begin
                if (altitude_results.size() == 0) begin
                    $error("result item with no prediction waiting: result_time %0h",
                           o_result_time);
                    mismatches++;
                end else begin
                    want = altitude_results.pop_front();
                    if (o_result_time !== want.stamp) begin
                        $error("result_time mismatch: expected %0h, actual %0h",
                               want.stamp, o_result_time);
                        mismatches++;
                    end
                    if (o_altitude_mm !== want.altitude) begin
                        $error("altitude_mm mismatch: expected %0d, actual %0d",
                               want.altitude, o_altitude_mm);
                        mismatches++;
                    end
                    if (o_height_mm !== want.height) begin
                        $error("height_mm mismatch: expected %0d, actual %0d",
                               want.height, o_height_mm);
                        mismatches++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                alt = altitude_of(i_pressure_pa, i_temperature_centi);
                if (launch_stamp == 64'd0) begin
                    origin_alt = alt;
                    launch_stamp = i_sample_time;
                end
                want.stamp = i_sample_time;
                want.altitude = alt;
                want.height = saturate27(longint'(alt) - longint'(origin_alt));
                altitude_results.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending <= altitude_results.size();
    end

endmodule

@@ tb/tb_baro_altitude_and_height_top.sv @@
`timescale 1ns / 1ps
// Testbench top that drives samples and the sea-level register and gives the verdict.
module tb_baro_altitude_and_height_top;
    import bal_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 135;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [16:0]        i_cfg_wr_data = '0;
    logic               i_valid = 1'b0;
    logic [63:0]        i_sample_time = '0;
    logic [16:0]        i_pressure_pa = '0;
    logic signed [14:0] i_temperature_centi = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [63:0]        o_result_time;
    logic signed [26:0] o_altitude_mm;
    logic signed [26:0] o_height_mm;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    int hold_left = 0;
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;

    baro_altitude_and_height_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample_time       (i_sample_time),
        .i_pressure_pa       (i_pressure_pa),
        .i_temperature_centi (i_temperature_centi),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_time       (o_result_time),
        .o_altitude_mm       (o_altitude_mm),
        .o_height_mm         (o_height_mm)
    );

    baro_altitude_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample_time       (i_sample_time),
        .i_pressure_pa       (i_pressure_pa),
        .i_temperature_centi (i_temperature_centi),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_time       (o_result_time),
        .o_altitude_mm       (o_altitude_mm),
        .o_height_mm         (o_height_mm),
        .o_fail_count        (fail_count),
        .o_pending           (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            i_stall <= !no_idle && ($urandom_range(99) < 30);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] random_stamp();
        return {$urandom, $urandom};
    endfunction

    task automatic send_sample(input logic [63:0] stamp, input logic [16:0] pressure,
                               input logic signed [14:0] temp_c);
        if (!no_idle) begin
            while ($urandom_range(99) < 30) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_sample_time <= stamp;
        i_pressure_pa <= pressure;
        i_temperature_centi <= temp_c;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_sea_level(input logic [16:0] level);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= level;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [16:0]        level;
        logic [16:0]        pressure;
        logic signed [14:0] temp_c;
        int                 pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A zero timestamp leaves the launch point open, so the third sample captures it.
        write_sea_level(17'd0);
        send_sample(64'd0, 17'd50000, 15'sd0);
        send_sample(64'd0, 17'd101325, 15'sd2500);
        send_sample(64'd1, 17'd131071, 15'sd16383);
        send_sample({64{1'b1}}, 17'd0, -15'sd16384);
        send_sample(random_stamp(), 17'd999, -15'sd4000);
        send_sample(random_stamp(), 17'd1000, 15'sd8500);
        send_sample(random_stamp(), 17'd1001, 15'sd0);
        send_sample(random_stamp(), 17'd1023, 15'sd1);
        send_sample(random_stamp(), 17'd1024, -15'sd1);
        send_sample(random_stamp(), 17'd32768, 15'sd2000);
        send_sample(random_stamp(), 17'd65535, 15'sd3000);
        send_sample(random_stamp(), 17'd65536, -15'sd2000);
        send_sample(random_stamp(), 17'd120000, 15'sd16383);
        send_sample(random_stamp(), 17'd120001, -15'sd16384);
        drain_results();

        // With the largest sea-level reference the height above a very low launch saturates.
        write_sea_level(17'd131071);
        send_sample(random_stamp(), 17'd0, 15'sd16383);
        send_sample(random_stamp(), 17'd1000, 15'sd8500);
        send_sample(random_stamp(), 17'd120000, -15'sd16384);
        send_sample(random_stamp(), 17'd60000, -15'sd4000);
        drain_results();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    level = P_MIN;
                end
                1: begin
                    level = P_MAX;
                end
                2: begin
                    level = 17'd80000;
                end
                3: begin
                    level = SEA_RESET;
                end
                4: begin
                    level = 17'($urandom_range(120000, 80000));
                end
                default: begin
                    level = 17'($urandom_range(131071, 0));
                end
            endcase
            write_sea_level(level);
            no_idle <= (ph == 2);
            if (ph == 4) begin
                hold_request <= 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    pressure = 17'($urandom_range(120000, 1000));
                end else if (pick < 92) begin
                    pressure = 17'($urandom);
                end else begin
                    case ($urandom_range(5))
                        0: pressure = 17'd0;
                        1: pressure = 17'd999;
                        2: pressure = 17'd1000;
                        3: pressure = 17'd120000;
                        4: pressure = 17'd120001;
                        default: pressure = 17'd131071;
                    endcase
                end
                if ($urandom_range(99) < 85) begin
                    temp_c = 15'($signed($urandom_range(12500, 0)) - 4000);
                end else begin
                    temp_c = 15'($urandom);
                end
                send_sample(random_stamp(), pressure, temp_c);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bal_pkg.sv
hdl/bal_log_front.sv
hdl/bal_engine.sv
hdl/baro_altitude_and_height_top.sv
hdl/bal_checker.sv
tb/baro_altitude_checker.sv
tb/tb_baro_altitude_and_height_top.sv
